### rtl/core/rtcm3fd_pkg.sv
// ----------------------------------------------------------------------------
// RTCM3 deframer package
// Shared constants, phase and kind codes, and the result record for the
// RTCM3 frame deframer with CRC-24Q check.
// ----------------------------------------------------------------------------
package rtcm3fd_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned KindW    = 2;
    localparam int unsigned IdW      = 12;
    localparam int unsigned LenW     = 10;
    localparam int unsigned CrcW     = 24;
    localparam int unsigned TdataW   = 56;
    localparam int unsigned OutDataW = ByteW + IdW + LenW + CrcW;

    localparam logic [ByteW-1:0] Preamble     = 8'hD3;
    localparam logic [ByteW-1:0] ReservedMask = 8'hFC;
    localparam logic [CrcW-1:0]  Crc24Poly    = 24'h864CFB;
    localparam logic [CrcW-1:0]  Crc24Init    = 24'h000000;
    localparam logic [1:0]       CrcByteLast  = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_HDR2    = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC     = 3'd4
    } phase_t;

    typedef enum logic [KindW-1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_CRC_PASS = 2'd1,
        KIND_CRC_FAIL = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [ByteW-1:0] payload_byte;
        logic [IdW-1:0]   message_id;
        logic [LenW-1:0]  frame_length;
        logic [CrcW-1:0]  computed_crc;
    } result_t;

endpackage

### rtl/core/rtcm3fd_crc_step.sv
// ----------------------------------------------------------------------------
// CRC-24Q byte update
// Advances a CRC-24Q remainder (polynomial 0x1864CFB) by one message byte,
// most significant bit first.
// ----------------------------------------------------------------------------
module rtcm3fd_crc_step (
    input  logic [rtcm3fd_pkg::CrcW-1:0]  crc_in,
    input  logic [rtcm3fd_pkg::ByteW-1:0] data_in,
    output logic [rtcm3fd_pkg::CrcW-1:0]  crc_out
);
    import rtcm3fd_pkg::*;

    always_comb begin
        logic [CrcW-1:0] r;
        r = crc_in ^ {data_in, {(CrcW-ByteW){1'b0}}};
        for (int k = 0; k < ByteW; k++) begin
            if (r[CrcW-1]) begin
                r = {r[CrcW-2:0], 1'b0} ^ Crc24Poly;
            end else begin
                r = {r[CrcW-2:0], 1'b0};
            end
        end
        crc_out = r;
    end

endmodule

### rtl/core/rtcm3fd_parser.sv
// ----------------------------------------------------------------------------
// RTCM3 frame parser
// Framing state machine: hunts for the preamble, reads the header, passes
// payload bytes through and checks the received CRC at the end of a frame.
// ----------------------------------------------------------------------------
module rtcm3fd_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          byte_valid,
    input  logic [rtcm3fd_pkg::ByteW-1:0] byte_data,
    output logic                          res_valid,
    output rtcm3fd_pkg::result_t          res_data
);
    import rtcm3fd_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [LenW-1:0]  length_reg, length_next;
    logic [LenW-1:0]  seen_reg, seen_next;
    logic [CrcW-1:0]  crc_reg, crc_next;
    logic [CrcW-1:0]  rx_crc_reg, rx_crc_next;
    logic [IdW-1:0]   id_reg, id_next;
    logic [1:0]       hdr_high_reg, hdr_high_next;

    logic [CrcW-1:0]  crc_base;
    logic [CrcW-1:0]  crc_upd;
    logic [LenW-1:0]  seen_inc;
    logic [LenW-1:0]  hdr_length;
    logic [CrcW-1:0]  rx_crc_shift;

    assign crc_base     = (phase_reg == PH_HUNT) ? Crc24Init : crc_reg;
    assign seen_inc     = seen_reg + 1'b1;
    assign hdr_length   = {hdr_high_reg, byte_data};
    assign rx_crc_shift = {rx_crc_reg[CrcW-ByteW-1:0], byte_data};

    rtcm3fd_crc_step u_crc (
        .crc_in  (crc_base),
        .data_in (byte_data),
        .crc_out (crc_upd)
    );

    always_comb begin
        phase_next = phase_reg;
        if (byte_valid) begin
            case (phase_reg)
                PH_HDR1: begin
                    phase_next = ((byte_data & ReservedMask) != '0) ? PH_HUNT : PH_HDR2;
                end
                PH_HDR2: begin
                    phase_next = (hdr_length != '0) ? PH_PAYLOAD : PH_CRC;
                end
                PH_PAYLOAD: begin
                    phase_next = (seen_inc >= length_reg) ? PH_CRC : PH_PAYLOAD;
                end
                PH_CRC: begin
                    phase_next = (seen_reg[1:0] == CrcByteLast) ? PH_HUNT : PH_CRC;
                end
                default: begin
                    phase_next = (byte_data == Preamble) ? PH_HDR1 : PH_HUNT;
                end
            endcase
        end
    end

    always_comb begin
        length_next   = length_reg;
        seen_next     = seen_reg;
        crc_next      = crc_reg;
        rx_crc_next   = rx_crc_reg;
        id_next       = id_reg;
        hdr_high_next = hdr_high_reg;
        res_valid     = 1'b0;
        res_data      = '0;
        if (byte_valid) begin
            case (phase_reg)
                PH_HDR1: begin
                    if ((byte_data & ReservedMask) == '0) begin
                        hdr_high_next = byte_data[1:0];
                        crc_next      = crc_upd;
                    end
                end
                PH_HDR2: begin
                    length_next = hdr_length;
                    crc_next    = crc_upd;
                    seen_next   = '0;
                    id_next     = '0;
                    rx_crc_next = '0;
                end
                PH_PAYLOAD: begin
                    crc_next = crc_upd;
                    if (seen_reg == '0) begin
                        id_next = {byte_data, 4'h0};
                    end else if (seen_reg == LenW'(1)) begin
                        id_next = id_reg | {{(IdW-4){1'b0}}, byte_data[7:4]};
                    end
                    seen_next = (seen_inc >= length_reg) ? '0 : seen_inc;
                    res_valid             = 1'b1;
                    res_data.kind         = KIND_PAYLOAD;
                    res_data.payload_byte = byte_data;
                end
                PH_CRC: begin
                    rx_crc_next = rx_crc_shift;
                    if (seen_reg[1:0] == CrcByteLast) begin
                        seen_next             = '0;
                        res_valid             = 1'b1;
                        res_data.kind         = (rx_crc_shift == crc_reg) ? KIND_CRC_PASS
                                                                          : KIND_CRC_FAIL;
                        res_data.message_id   = (length_reg >= LenW'(2)) ? id_reg : '0;
                        res_data.frame_length = length_reg;
                        res_data.computed_crc = crc_reg;
                    end else begin
                        seen_next = seen_inc;
                    end
                end
                default: begin
                    if (byte_data == Preamble) begin
                        crc_next = crc_upd;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HUNT;
            length_reg   <= '0;
            seen_reg     <= '0;
            crc_reg      <= Crc24Init;
            rx_crc_reg   <= '0;
            id_reg       <= '0;
            hdr_high_reg <= '0;
        end else begin
            phase_reg    <= phase_next;
            length_reg   <= length_next;
            seen_reg     <= seen_next;
            crc_reg      <= crc_next;
            rx_crc_reg   <= rx_crc_next;
            id_reg       <= id_next;
            hdr_high_reg <= hdr_high_next;
        end
    end

endmodule

### rtl/core/rtcm3fd_out_buf.sv
// ----------------------------------------------------------------------------
// Result buffer
// Two-entry result queue that registers each result and keeps the input
// side open while one result waits on the output.
// ----------------------------------------------------------------------------
module rtcm3fd_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  rtcm3fd_pkg::result_t push_data,
    output logic                 full,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rtcm3fd_pkg::result_t out_data
);
    import rtcm3fd_pkg::*;

    result_t    entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/core/rtcm3_frame_deframer_crc24q_core.sv
// ----------------------------------------------------------------------------
// RTCM3 frame deframer with CRC-24Q check
// Extracts RTCM3 frames from a byte stream, forwards payload bytes and
// reports CRC pass or fail, message ID and length at the end of each frame.
//
// Channel  Dir  Content
// s_*      in   one raw stream byte per transaction
// m_*      out  one payload byte or one end-of-frame report per transaction
//
// One byte is accepted per cycle while s_tready is high; the parser updates its
// state and CRC in the cycle of acceptance and pushes each result into the queue.
// A two-entry result queue keeps s_tready high while one result is stalled,
// so s_tready drops only when two results are waiting.
// Reset is synchronous; afterwards the block hunts for a preamble and the
// result queue is empty.
// ----------------------------------------------------------------------------
module rtcm3_frame_deframer_crc24q_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rtcm3fd_pkg::ByteW-1:0]   s_tdata,   // [7:0] data_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rtcm3fd_pkg::TdataW-1:0]  m_tdata,   // [7:0] payload_byte,
                                                       // [19:8] message_id,
                                                       // [29:20] frame_length,
                                                       // [53:30] computed_crc
    output logic [rtcm3fd_pkg::KindW-1:0]   m_tuser    // [1:0] kind
);
    import rtcm3fd_pkg::*;

    logic    buf_full;
    logic    accept;
    logic    res_valid;
    result_t res_data;
    result_t out_data;

    assign s_tready = !buf_full;
    assign accept   = s_tvalid && s_tready;

    rtcm3fd_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (accept),
        .byte_data  (s_tdata),
        .res_valid  (res_valid),
        .res_data   (res_data)
    );

    rtcm3fd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res_data),
        .full      (buf_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tuser = out_data.kind;
    assign m_tdata = {{(TdataW-OutDataW){1'b0}},
                      out_data.computed_crc,
                      out_data.frame_length,
                      out_data.message_id,
                      out_data.payload_byte};

endmodule

### test/rtcm3fd_frame_checker.sv
// ----------------------------------------------------------------------------
// RTCM3 deframer checker
// Watches the byte input and the result output of the deframer, rebuilds the
// framing state and CRC-24Q from every accepted input byte, and compares each
// accepted result field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
package rtcm3fd_tb_pkg;

    import rtcm3fd_pkg::*;

    function automatic logic [CrcW-1:0] crc24q_update(input logic [CrcW-1:0] crc,
                                                      input logic [ByteW-1:0] b);
        logic [CrcW-1:0] c;
        int k;
        c = crc ^ {b, 16'h0000};
        for (k = 0; k < 8; k++) begin
            c = c[CrcW-1] ? ((c << 1) ^ Crc24Poly) : (c << 1);
        end
        return c;
    endfunction

endpackage

module rtcm3fd_frame_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [rtcm3fd_pkg::ByteW-1:0]   s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [rtcm3fd_pkg::TdataW-1:0]  m_tdata,
    input  logic [rtcm3fd_pkg::KindW-1:0]   m_tuser,
    output int                              fail_count,
    output int                              pending
);

    import rtcm3fd_pkg::*;
    import rtcm3fd_tb_pkg::*;

    phase_t          stage;
    logic [LenW-1:0] len_total;
    logic [LenW-1:0] len_count;
    logic [CrcW-1:0] crc_acc;
    logic [CrcW-1:0] crc_rx;
    logic [IdW-1:0]  msg_id;
    logic [1:0]      len_hi;
    result_t         frame_results_due[$];

    task automatic deframe_byte(input logic [ByteW-1:0] b);
        result_t r;
        r = '{kind: KIND_PAYLOAD, default: '0};
        case (stage)
            PH_HDR1: begin
                if ((b & ReservedMask) != '0) begin
                    stage = PH_HUNT;
                end else begin
                    len_hi  = b[1:0];
                    crc_acc = crc24q_update(crc_acc, b);
                    stage   = PH_HDR2;
                end
            end
            PH_HDR2: begin
                len_total = {len_hi, b};
                crc_acc   = crc24q_update(crc_acc, b);
                len_count = '0;
                msg_id    = '0;
                crc_rx    = '0;
                stage     = (len_total != '0) ? PH_PAYLOAD : PH_CRC;
            end
            PH_PAYLOAD: begin
                crc_acc = crc24q_update(crc_acc, b);
                if (len_count == 0) begin
                    msg_id = {b, 4'h0};
                end else if (len_count == 1) begin
                    msg_id[3:0] = b[7:4];
                end
                len_count = len_count + 1'b1;
                if (len_count >= len_total) begin
                    len_count = '0;
                    stage     = PH_CRC;
                end
                r.payload_byte = b;
                frame_results_due = {frame_results_due, r};
            end
            PH_CRC: begin
                crc_rx    = {crc_rx[15:0], b};
                len_count = len_count + 1'b1;
                if (len_count == 3) begin
                    r.kind         = (crc_rx == crc_acc) ? KIND_CRC_PASS : KIND_CRC_FAIL;
                    r.message_id   = (len_total >= 2) ? msg_id : '0;
                    r.frame_length = len_total;
                    r.computed_crc = crc_acc;
                    frame_results_due = {frame_results_due, r};
                    len_count = '0;
                    stage     = PH_HUNT;
                end
            end
            default: begin
                if (b == Preamble) begin
                    crc_acc = crc24q_update(Crc24Init, b);
                    stage   = PH_HDR1;
                end else begin
                    stage = PH_HUNT;
                end
            end
        endcase
    endtask

    task automatic check_result();
        result_t exp_r;
        result_t got;
        got.kind         = kind_t'(m_tuser);
        got.payload_byte = m_tdata[7:0];
        got.message_id   = m_tdata[19:8];
        got.frame_length = m_tdata[29:20];
        got.computed_crc = m_tdata[53:30];
        if (frame_results_due.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("Unexpected result: kind %0d byte %h id %h len %0d crc %h",
                         got.kind, got.payload_byte, got.message_id, got.frame_length,
                         got.computed_crc);
            end
        end else begin
            exp_r = frame_results_due.pop_front();
            if (got.kind !== exp_r.kind || got.payload_byte !== exp_r.payload_byte ||
                    got.message_id !== exp_r.message_id ||
                    got.frame_length !== exp_r.frame_length ||
                    got.computed_crc !== exp_r.computed_crc) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("Mismatch: kind %0d/%0d byte %h/%h id %h/%h len %0d/%0d",
                             exp_r.kind, got.kind, exp_r.payload_byte, got.payload_byte,
                             exp_r.message_id, got.message_id, exp_r.frame_length,
                             got.frame_length);
                    $display("  crc %h/%h (expected/actual)",
                             exp_r.computed_crc, got.computed_crc);
                end
            end
        end
    endtask

    initial begin
        fail_count = 0;
        pending    = 0;
        stage      = PH_HUNT;
        len_total  = '0;
        len_count  = '0;
        crc_acc    = Crc24Init;
        crc_rx     = '0;
        msg_id     = '0;
        len_hi     = '0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            stage     = PH_HUNT;
            len_total = '0;
            len_count = '0;
            crc_acc   = Crc24Init;
            crc_rx    = '0;
            msg_id    = '0;
            len_hi    = '0;
            frame_results_due.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                deframe_byte(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                check_result();
            end
        end
        pending = frame_results_due.size();
    end

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// RTCM3 deframer testbench
// Feeds directed and random byte streams (well-formed frames with good and bad
// CRCs, noise, bad headers and cut-off frames) into the deframer under bursty
// input and a stalling output, and takes the verdict from the frame checker.
// ----------------------------------------------------------------------------
module tb;

    import rtcm3fd_pkg::*;
    import rtcm3fd_tb_pkg::*;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [ByteW-1:0]  s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [TdataW-1:0] m_tdata;
    logic [KindW-1:0]  m_tuser;
    int                fail_count;
    int                pending;

    logic [ByteW-1:0]  frame_q[$];
    int                burst_left;
    int                sent_count;

    rtcm3_frame_deframer_crc24q_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    rtcm3fd_frame_checker u_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1000000;
        $display("Verification failed");
        $finish;
    end

    task automatic send_byte(input logic [ByteW-1:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        burst_left--;
        sent_count++;
    endtask

    task automatic make_frame(input int len, input int fill, input bit bad_crc);
        logic [CrcW-1:0]  crc;
        logic [ByteW-1:0] b;
        int i;
        frame_q.delete();
        frame_q = {frame_q, Preamble};
        frame_q = {frame_q, {6'd0, len[9:8]}};
        frame_q = {frame_q, len[7:0]};
        for (i = 0; i < len; i++) begin
            b = (fill < 0) ? ByteW'($urandom) : fill[7:0];
            frame_q = {frame_q, b};
        end
        crc = Crc24Init;
        foreach (frame_q[j]) begin
            crc = crc24q_update(crc, frame_q[j]);
        end
        if (bad_crc) begin
            crc ^= ($urandom_range(0, 1) == 1) ? (24'd1 << $urandom_range(0, 23))
                                               : CrcW'($urandom_range(1, 24'hFFFFFF));
        end
        frame_q = {frame_q, crc[23:16]};
        frame_q = {frame_q, crc[15:8]};
        frame_q = {frame_q, crc[7:0]};
    endtask

    task automatic send_frame(input int count);
        int i;
        for (i = 0; i < count; i++) begin
            send_byte(frame_q[i]);
        end
    endtask

    initial begin
        int mode;
        int mode_left;
        int stall_left;
        int cyc;
        mode       = 0;
        mode_left  = 0;
        stall_left = 0;
        cyc        = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(64, 256);
            end
            mode_left--;
            cyc++;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= (cyc % 4 == 0);
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        m_tready <= 1'b0;
                    end else begin
                        m_tready <= 1'b1;
                        if ($urandom_range(0, 7) == 0) begin
                            stall_left = $urandom_range(1, 12);
                        end
                    end
                end
            endcase
        end
    end

    initial begin
        int r;
        int len;
        int fill;
        int n;
        int i;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        burst_left = 0;
        sent_count = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(Preamble);
        send_byte(Preamble);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(Preamble);
        send_byte(8'hFC);
        make_frame(0, -1, 1'b0);
        send_frame(frame_q.size());
        make_frame(1, 8'hFF, 1'b0);
        send_frame(frame_q.size());
        make_frame(2, 8'hFF, 1'b0);
        send_frame(frame_q.size());
        make_frame(2, 8'h00, 1'b1);
        send_frame(frame_q.size());
        make_frame(3, -1, 1'b1);
        send_frame(frame_q.size());
        make_frame(0, -1, 1'b1);
        send_frame(frame_q.size());
        make_frame(1023, -1, 1'b0);
        send_frame(frame_q.size());

        while (sent_count < 1900) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 39) == 0) begin
                len = $urandom_range(256, 600);
            end else begin
                len = $urandom_range(0, 24);
            end
            case ($urandom_range(0, 7))
                0: fill = 8'h00;
                1: fill = 8'hFF;
                default: fill = -1;
            endcase
            if (r < 70) begin
                make_frame(len, fill, $urandom_range(0, 99) < 15);
                send_frame(frame_q.size());
            end else if (r < 80) begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++) begin
                    send_byte(ByteW'($urandom));
                end
            end else if (r < 90) begin
                send_byte(Preamble);
                send_byte(ByteW'($urandom_range(4, 255)));
            end else begin
                make_frame($urandom_range(0, 6), -1, 1'b0);
                send_frame($urandom_range(1, frame_q.size() - 1));
            end
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
